// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/fpbwb_pkg.sv =====
package fpbwb_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int ADDR_W   = 21;
    localparam int LEN_W    = 13;
    localparam int MEM_W    = 16;
    localparam int CMD_W    = 3;
    localparam int PAGE_W   = 12;
    localparam int OFF_W    = 9;
    localparam int ROOM_W   = OFF_W + 1;
    localparam int TDATA_W  = 56;

    // page geometry and request limit
    localparam logic [ROOM_W-1:0] PageBytes  = ROOM_W'(512);
    localparam logic [LEN_W-1:0]  MaxRequest = LEN_W'(4096);

    // request operations
    localparam logic [OP_W-1:0] OP_READ   = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMMIT = 2'd2;

    // flash commands
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT      = 3'd0,
        CMD_REWRITE  = 3'd1,
        CMD_GET      = 3'd2,
        CMD_BUFWRITE = 3'd3,
        CMD_READ     = 3'd4
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
        t_cmd kind;
        logic last;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            valid;
        logic            len_zero;
        logic            final_chunk;
        logic            slot_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/flash_page_buffer_write_back.sv =====
// flash page buffer write-back planner
// slave channel: one request word per handshake; tuser carries the operation
//   (read, write, commit), tdata the byte address, length and data pointer
// master channel: one flash command per word; tuser carries the command code,
//   tdata the page, offset, byte count and memory location, tlast marks the
//   final command of a request
// a request is taken only while the planner is idle; it is registered, then
//   decided on, and its first command then goes into the output register
// after that, while the master side accepts, one command per cycle leaves the
//   output register, and each write chunk after the first is decided on again
// requests that produce no command (empty write, commit of a clean buffer,
//   unused operation code) return to idle after the decide state
// the next request is taken while the last command still waits in the output
//   register
// a stalled master side holds the command word and halts the command states
// reset clears the buffered page, its valid flag and the rewrite counter
module flash_page_buffer_write_back (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,  // operation
    input  logic [55:0] i_s_axis_tdata,  // byte_address, length, data_pointer
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [2:0]  o_m_axis_tuser,  // command
    output logic [55:0] o_m_axis_tdata,  // page, offset, count, memory_location
    output logic        o_m_axis_tlast   // last
);

    fpbwb_pkg::t_dp_ctl  ctl;
    fpbwb_pkg::t_dp_stat stat;
    fpbwb_pkg::t_cmd     out_cmd;
    logic [fpbwb_pkg::PAGE_W-1:0] out_page;
    logic [fpbwb_pkg::OFF_W-1:0]  out_off;
    logic [fpbwb_pkg::LEN_W-1:0]  out_count;
    logic [fpbwb_pkg::MEM_W-1:0]  out_mem;

    // sequencer
    fpbwb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_stat      (stat),
        .o_req_ready (o_s_axis_tready),
        .o_ctl       (ctl)
    );

    // request, cache state and output word
    fpbwb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_op        (i_s_axis_tuser),
        .i_addr      (i_s_axis_tdata[20:0]),
        .i_len       (i_s_axis_tdata[33:21]),
        .i_mem       (i_s_axis_tdata[49:34]),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_cmd   (out_cmd),
        .o_out_page  (out_page),
        .o_out_off   (out_off),
        .o_out_count (out_count),
        .o_out_mem   (out_mem),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = out_cmd;
    assign o_m_axis_tdata = {6'b0, out_mem, out_count, out_off, out_page};

endmodule

// ===== hw/rtl/fpbwb_ctrl.sv =====
module fpbwb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  fpbwb_pkg::t_dp_stat i_stat,
    output logic                o_req_ready,
    output fpbwb_pkg::t_dp_ctl  o_ctl
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECIDE  = 7'b0000010,
        ST_PUT     = 7'b0000100,
        ST_REWRITE = 7'b0001000,
        ST_GET     = 7'b0010000,
        ST_BUFW    = 7'b0100000,
        ST_READ    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_ctl.load = 1'b0;
        o_ctl.emit = 1'b0;
        o_ctl.kind = fpbwb_pkg::CMD_PUT;
        o_ctl.last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.load = i_req_valid;
                if (i_req_valid) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                case (i_stat.op)
                    fpbwb_pkg::OP_READ: begin
                        n_state = i_stat.hit ? ST_PUT : ST_READ;
                    end
                    fpbwb_pkg::OP_WRITE: begin
                        if (i_stat.len_zero) begin
                            n_state = ST_IDLE;
                        end else if (i_stat.hit) begin
                            n_state = ST_BUFW;
                        end else if (i_stat.valid) begin
                            n_state = ST_PUT;
                        end else begin
                            n_state = ST_GET;
                        end
                    end
                    fpbwb_pkg::OP_COMMIT: begin
                        n_state = i_stat.valid ? ST_PUT : ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_PUT: begin
                o_ctl.kind = fpbwb_pkg::CMD_PUT;
                o_ctl.emit = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    n_state = ST_REWRITE;
                end
            end
            ST_REWRITE: begin
                o_ctl.kind = fpbwb_pkg::CMD_REWRITE;
                o_ctl.last = (i_stat.op == fpbwb_pkg::OP_COMMIT);
                o_ctl.emit = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    case (i_stat.op)
                        fpbwb_pkg::OP_READ:  n_state = ST_READ;
                        fpbwb_pkg::OP_WRITE: n_state = ST_GET;
                        default:             n_state = ST_IDLE;
                    endcase
                end
            end
            ST_GET: begin
                o_ctl.kind = fpbwb_pkg::CMD_GET;
                o_ctl.emit = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    n_state = ST_BUFW;
                end
            end
            ST_BUFW: begin
                o_ctl.kind = fpbwb_pkg::CMD_BUFWRITE;
                o_ctl.last = i_stat.final_chunk;
                o_ctl.emit = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    n_state = i_stat.final_chunk ? ST_IDLE : ST_DECIDE;
                end
            end
            ST_READ: begin
                o_ctl.kind = fpbwb_pkg::CMD_READ;
                o_ctl.last = 1'b1;
                o_ctl.emit = i_stat.slot_free;
                if (i_stat.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/fpbwb_dp.sv =====
module fpbwb_dp (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  fpbwb_pkg::t_dp_ctl                       i_ctl,
    input  logic [fpbwb_pkg::OP_W-1:0]               i_op,
    input  logic [fpbwb_pkg::ADDR_W-1:0]             i_addr,
    input  logic [fpbwb_pkg::LEN_W-1:0]              i_len,
    input  logic [fpbwb_pkg::MEM_W-1:0]              i_mem,
    input  logic                                     i_out_ready,
    output fpbwb_pkg::t_dp_stat                      o_stat,
    output logic                                     o_out_valid,
    output fpbwb_pkg::t_cmd                          o_out_cmd,
    output logic [fpbwb_pkg::PAGE_W-1:0]             o_out_page,
    output logic [fpbwb_pkg::OFF_W-1:0]              o_out_off,
    output logic [fpbwb_pkg::LEN_W-1:0]              o_out_count,
    output logic [fpbwb_pkg::MEM_W-1:0]              o_out_mem,
    output logic                                     o_out_last
);

    localparam int PAGE_W  = fpbwb_pkg::PAGE_W;
    localparam int OFF_W   = fpbwb_pkg::OFF_W;
    localparam int LEN_W   = fpbwb_pkg::LEN_W;
    localparam int MEM_W   = fpbwb_pkg::MEM_W;
    localparam int ROOM_W  = fpbwb_pkg::ROOM_W;
    localparam int ADDR_HI = OFF_W + PAGE_W - 1;

    // request under work
    logic [fpbwb_pkg::OP_W-1:0] r_op;
    logic [PAGE_W-1:0]          r_page;
    logic [OFF_W-1:0]           r_off;
    logic [LEN_W-1:0]           r_len;
    logic [MEM_W-1:0]           r_mem;

    // cache state
    logic [PAGE_W-1:0]          r_buf_page;
    logic                       r_buf_valid;
    logic [PAGE_W-1:0]          r_rw_cnt;

    // output word register
    logic                       r_out_valid;
    fpbwb_pkg::t_cmd            r_out_cmd;
    logic [PAGE_W-1:0]          r_out_page;
    logic [OFF_W-1:0]           r_out_off;
    logic [LEN_W-1:0]           r_out_count;
    logic [MEM_W-1:0]           r_out_mem;
    logic                       r_out_last;

    logic [ROOM_W-1:0]          room;
    logic                       final_chunk;
    logic [ROOM_W-1:0]          chunk;
    logic [LEN_W-1:0]           len_sat;
    logic                       slot_free;

    // chunk of the current write: rest of the page or rest of the request
    assign room        = fpbwb_pkg::PageBytes - {1'b0, r_off};
    assign final_chunk = (r_len <= {{(LEN_W-ROOM_W){1'b0}}, room});
    assign chunk       = final_chunk ? r_len[ROOM_W-1:0] : room;
    assign len_sat     = (i_len > fpbwb_pkg::MaxRequest) ? fpbwb_pkg::MaxRequest : i_len;
    assign slot_free   = !r_out_valid || i_out_ready;

    // status to the controller
    always_comb begin
        o_stat.op          = r_op;
        o_stat.hit         = r_buf_valid && (r_page == r_buf_page);
        o_stat.valid       = r_buf_valid;
        o_stat.len_zero    = (r_len == '0);
        o_stat.final_chunk = final_chunk;
        o_stat.slot_free   = slot_free;
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_op   <= i_op;
            r_page <= i_addr[ADDR_HI:OFF_W];
            r_off  <= i_addr[OFF_W-1:0];
            r_len  <= len_sat;
            r_mem  <= i_mem;
        end else if (i_ctl.emit && (i_ctl.kind == fpbwb_pkg::CMD_BUFWRITE)) begin
            r_page <= r_page + PAGE_W'(1);
            r_off  <= '0;
            r_len  <= r_len - {{(LEN_W-ROOM_W){1'b0}}, chunk};
            r_mem  <= r_mem + MEM_W'(chunk);
        end
    end

    // buffered page and auto-rewrite counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_page  <= '0;
            r_buf_valid <= 1'b0;
            r_rw_cnt    <= '0;
        end else if (i_ctl.emit) begin
            case (i_ctl.kind)
                fpbwb_pkg::CMD_REWRITE: begin
                    r_rw_cnt    <= r_rw_cnt + PAGE_W'(1);
                    r_buf_valid <= 1'b0;
                end
                fpbwb_pkg::CMD_GET: begin
                    r_buf_page  <= r_page;
                    r_buf_valid <= 1'b1;
                end
                default: begin
                    r_buf_valid <= r_buf_valid;
                end
            endcase
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_out_cmd   <= i_ctl.kind;
            r_out_last  <= i_ctl.last;
            r_out_off   <= '0;
            r_out_count <= '0;
            r_out_mem   <= '0;
            case (i_ctl.kind)
                fpbwb_pkg::CMD_PUT: begin
                    r_out_page <= r_buf_page;
                end
                fpbwb_pkg::CMD_REWRITE: begin
                    r_out_page <= r_rw_cnt;
                end
                fpbwb_pkg::CMD_BUFWRITE: begin
                    r_out_page  <= r_page;
                    r_out_off   <= r_off;
                    r_out_count <= {{(LEN_W-ROOM_W){1'b0}}, chunk};
                    r_out_mem   <= r_mem;
                end
                fpbwb_pkg::CMD_READ: begin
                    r_out_page  <= r_page;
                    r_out_off   <= r_off;
                    r_out_count <= r_len;
                    r_out_mem   <= r_mem;
                end
                default: begin
                    r_out_page <= r_page;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_cmd   = r_out_cmd;
    assign o_out_page  = r_out_page;
    assign o_out_off   = r_out_off;
    assign o_out_count = r_out_count;
    assign o_out_mem   = r_out_mem;
    assign o_out_last  = r_out_last;

endmodule

// ===== hw/rtl/fpbwb_checker.sv =====
`include "assert_macros.svh"

module fpbwb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [1:0]  i_s_axis_tuser,
    input logic [55:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [2:0]  o_m_axis_tuser,
    input logic [55:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic m_stall;
    logic page_op;
    logic direct_rd;
    logic in_take;

    assign m_stall   = o_m_axis_tvalid && !i_m_axis_tready;
    assign page_op   = o_m_axis_tvalid &&
                       ((o_m_axis_tuser == fpbwb_pkg::CMD_PUT) ||
                        (o_m_axis_tuser == fpbwb_pkg::CMD_REWRITE) ||
                        (o_m_axis_tuser == fpbwb_pkg::CMD_GET));
    assign direct_rd = o_m_axis_tvalid && (o_m_axis_tuser == fpbwb_pkg::CMD_READ);
    assign in_take   = i_s_axis_tvalid && o_s_axis_tready;

    // stalled command word holds
    `ASSERT_NEXT(a_m_hold, i_clk, i_rst_n, m_stall, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "command word changed under stall")

    // page commands carry no offset, count or memory location
    `ASSERT_NOW(a_page_op_zero, i_clk, i_rst_n, page_op, o_m_axis_tdata[49:12] == '0, "page command with data fields")

    // a direct read always ends its request
    `ASSERT_NOW(a_read_last, i_clk, i_rst_n, direct_rd, o_m_axis_tlast, "direct read without last")

    // when no command waits, none can appear and ready drops in the cycle right after a request is taken
    `ASSERT_NEXT(a_no_early_cmd, i_clk, i_rst_n, in_take && !o_m_axis_tvalid, !o_m_axis_tvalid && !o_s_axis_tready, "command or ready right after acceptance")

endmodule

bind flash_page_buffer_write_back fpbwb_checker u_fpbwb_checker (.*);

// ===== tb/fpbwb_command_checker.sv =====
`timescale 1ns / 1ps

module fpbwb_command_checker
    import fpbwb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [1:0]  i_s_axis_tuser,   // operation
    input  logic [55:0] i_s_axis_tdata,   // byte_address, length, data_pointer
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [2:0]  i_m_axis_tuser,   // command
    input  logic [55:0] i_m_axis_tdata,   // page, offset, count, memory_location
    input  logic        i_m_axis_tlast,
    output int          o_mismatch_count,
    output int          o_pending_count,
    output int          o_request_count,
    output int          o_command_count
);

    typedef struct {
        t_cmd              kind;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  count;
        logic [MEM_W-1:0]  mem;
        logic              last;
    } flash_cmd_t;

    // commands still owed by the block, oldest first
    flash_cmd_t pending_flash_cmds[$];
    // commands of the request being planned
    flash_cmd_t request_cmds[$];

    // shadow of the chip buffer and the refresh sequence
    logic [PAGE_W-1:0] cached_page;
    logic              cached_valid;
    logic [PAGE_W-1:0] refresh_page;

    int mismatches = 0;
    int requests   = 0;
    int commands   = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at command word %0d: %s", commands, what);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic add_cmd(input t_cmd kind, input logic [PAGE_W-1:0] page,
                           input logic [OFF_W-1:0] offset, input logic [LEN_W-1:0] count,
                           input logic [MEM_W-1:0] mem);
        flash_cmd_t c;
        c.kind   = kind;
        c.page   = page;
        c.offset = offset;
        c.count  = count;
        c.mem    = mem;
        c.last   = 1'b0;
        request_cmds.push_back(c);
    endtask

    // flush the buffered page and refresh the next page in turn
    task automatic write_back_page();
        add_cmd(CMD_PUT, cached_page, '0, '0, '0);
        add_cmd(CMD_REWRITE, refresh_page, '0, '0, '0);
        refresh_page = refresh_page + 1'b1;
    endtask

    task automatic commit_buffer();
        if (cached_valid) begin
            write_back_page();
            cached_valid = 1'b0;
        end
    endtask

    // turn one request into the flash commands it should cause
    task automatic plan_flash_commands(input logic [OP_W-1:0] op,
                                       input logic [ADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len,
                                       input logic [MEM_W-1:0] ptr);
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  left;
        logic [LEN_W-1:0]  chunk;
        logic [MEM_W-1:0]  mem;
        page   = addr[ADDR_W-1:OFF_W];
        offset = addr[OFF_W-1:0];
        left   = (len > MaxRequest) ? MaxRequest : len;
        mem    = ptr;
        request_cmds.delete();
        case (op)
            OP_READ: begin
                if (cached_valid && page == cached_page)
                    commit_buffer();
                add_cmd(CMD_READ, page, offset, left, mem);
            end
            OP_WRITE: begin
                while (left != 0) begin
                    chunk = LEN_W'(PageBytes - ROOM_W'(offset));
                    if (chunk > left)
                        chunk = left;
                    if (!cached_valid || page != cached_page) begin
                        if (cached_valid)
                            write_back_page();
                        add_cmd(CMD_GET, page, '0, '0, '0);
                        cached_page  = page;
                        cached_valid = 1'b1;
                    end
                    add_cmd(CMD_BUFWRITE, page, offset, chunk, mem);
                    mem    = mem + MEM_W'(chunk);
                    left   = left - chunk;
                    offset = '0;
                    page   = page + 1'b1;
                end
            end
            OP_COMMIT: begin
                commit_buffer();
            end
            default: ;
        endcase
        if (request_cmds.size() > 0)
            request_cmds[request_cmds.size()-1].last = 1'b1;
        foreach (request_cmds[i])
            pending_flash_cmds.push_back(request_cmds[i]);
    endtask

    // compare one command word with the oldest expected one
    task automatic check_command();
        flash_cmd_t want;
        if (pending_flash_cmds.size() == 0) begin
            report_mismatch($sformatf("unexpected command %0h page %0h",
                                      i_m_axis_tuser, i_m_axis_tdata[11:0]));
            return;
        end
        want = pending_flash_cmds.pop_front();
        compare_field("command", 16'(i_m_axis_tuser), 16'(want.kind));
        compare_field("page", 16'(i_m_axis_tdata[11:0]), 16'(want.page));
        compare_field("offset", 16'(i_m_axis_tdata[20:12]), 16'(want.offset));
        compare_field("count", 16'(i_m_axis_tdata[33:21]), 16'(want.count));
        compare_field("memory location", i_m_axis_tdata[49:34], want.mem);
        compare_field("last", 16'(i_m_axis_tlast), 16'(want.last));
    endtask

    // watch both channels; requests are planned before commands are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cached_page  = '0;
            cached_valid = 1'b0;
            refresh_page = '0;
            pending_flash_cmds.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                requests++;
                plan_flash_commands(i_s_axis_tuser, i_s_axis_tdata[20:0],
                                    i_s_axis_tdata[33:21], i_s_axis_tdata[49:34]);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                check_command();
                commands++;
            end
        end
        o_mismatch_count = mismatches;
        o_pending_count  = pending_flash_cmds.size();
        o_request_count  = requests;
        o_command_count  = commands;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fpbwb_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int REQUEST_TARGET   = 360;
    localparam int QUIET_FROM       = 300;
    localparam int HOLD_AT_REQUEST  = 60;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 40;
    localparam int CYCLE_LIMIT      = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [1:0]  i_s_axis_tuser;   // operation
    logic [55:0] i_s_axis_tdata;   // byte_address, length, data_pointer
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [2:0]  o_m_axis_tuser;   // command
    logic [55:0] o_m_axis_tdata;   // page, offset, count, memory_location
    logic        o_m_axis_tlast;

    int mismatch_count;
    int pending_count;
    int request_count;
    int command_count;

    int                cycle_count    = 0;
    int                sent_reqs      = 0;
    logic              quiet          = 1'b0;
    logic              long_hold_req  = 1'b0;
    logic              long_hold_done = 1'b0;
    int                stall_left     = 0;
    logic [PAGE_W-1:0] hot_page       = '0;

    flash_page_buffer_write_back dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    fpbwb_command_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tuser   (i_s_axis_tuser),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tuser   (o_m_axis_tuser),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .i_m_axis_tlast   (o_m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_request_count  (request_count),
        .o_command_count  (command_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d commands outstanding",
                     cycle_count, pending_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // command receiver: short random stalls, one long hold-off
    initial begin
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_m_axis_tready = 1'b0;
                stall_left--;
            end else if (long_hold_req && !long_hold_done) begin
                long_hold_done  = 1'b1;
                i_m_axis_tready = 1'b0;
                stall_left      = LONG_HOLD_CYCLES - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready = 1'b0;
                stall_left      = $urandom_range(0, 3);
            end else begin
                i_m_axis_tready = 1'b1;
            end
        end
    end

    // offer one request word and wait for its handshake
    task automatic send_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] len, input logic [MEM_W-1:0] ptr);
        int               gap;
        int               tail;
        logic [LEN_W-1:0] span;
        quiet = (sent_reqs >= QUIET_FROM) || (sent_reqs >= 150 && sent_reqs < 190);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                i_s_axis_tvalid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = op;
        i_s_axis_tdata  = {6'b0, ptr, len, addr};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        // track the page a write leaves buffered, so later requests can hit it
        if (op == OP_WRITE && len != 0) begin
            span     = (len > MaxRequest) ? MaxRequest : len;
            tail     = int'(addr[OFF_W-1:0]) + int'(span) - 1;
            hot_page = addr[ADDR_W-1:OFF_W] + PAGE_W'(tail / 512);
        end
        sent_reqs++;
        if (sent_reqs == HOLD_AT_REQUEST)
            long_hold_req = 1'b1;
    endtask

    // random request, biased toward the buffered page to get hits
    task automatic random_request();
        int                pick;
        int                where;
        int                size_pick;
        logic [PAGE_W-1:0] page;
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        logic [MEM_W-1:0]  ptr;
        pick      = $urandom_range(0, 99);
        where     = $urandom_range(0, 9);
        size_pick = $urandom_range(0, 99);
        ptr       = MEM_W'($urandom);
        off       = OFF_W'($urandom);
        if (where < 5)
            page = hot_page;
        else if (where < 7)
            page = ($urandom_range(0, 1) == 0) ? hot_page + 1'b1 : hot_page - 1'b1;
        else
            page = PAGE_W'($urandom);
        if (size_pick < 10)
            len = LEN_W'($urandom_range(1, 64));
        else if (size_pick < 80)
            len = LEN_W'($urandom_range(1, 600));
        else if (size_pick < 95)
            len = LEN_W'($urandom_range(601, 4096));
        else
            len = LEN_W'($urandom_range(4097, 8191));
        if (pick < 50)
            send_request(OP_WRITE, {page, off}, len, ptr);
        else if (pick < 75)
            send_request(OP_READ, {page, off},
                         ($urandom_range(0, 9) == 0) ? '0 : len, ptr);
        else if (pick < 85)
            send_request(OP_COMMIT, ADDR_W'($urandom), LEN_W'($urandom), ptr);
        else if (pick < 90)
            send_request(OP_UNUSED, ADDR_W'($urandom), LEN_W'($urandom), ptr);
        else if (pick < 95)
            send_request(OP_WRITE, {page, off}, '0, ptr);
        else
            send_request(OP_WRITE, {hot_page, off},
                         LEN_W'($urandom_range(1, 512 - int'(off))), ptr);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tuser  = '0;
        i_s_axis_tdata  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // commit with nothing buffered, empty read, unused code, empty write
        send_request(OP_COMMIT, '0, '0, '0);
        send_request(OP_READ, '0, '0, '0);
        send_request(OP_UNUSED, '1, '1, '1);
        send_request(OP_WRITE, {12'd3, 9'd7}, '0, 16'h00ff);
        // miss then hit on one page, read of the buffered page commits it
        send_request(OP_WRITE, {12'd5, 9'd100}, 13'd50, 16'h1234);
        send_request(OP_WRITE, {12'd5, 9'd0}, 13'd10, 16'h4321);
        send_request(OP_READ, {12'd5, 9'd20}, 13'd64, 16'h0800);
        send_request(OP_COMMIT, '0, '0, '0);
        // page and memory wrap across the top of the array
        send_request(OP_WRITE, {12'd4095, 9'd500}, 13'd600, 16'hfff0);
        send_request(OP_COMMIT, '1, '1, '1);
        // longest write, saturated length, from the last byte of the array
        send_request(OP_WRITE, '1, '1, '1);
        send_request(OP_READ, '1, '1, '0);
        send_request(OP_READ, {12'd8, 9'd0}, 13'd4096, 16'h8000);
        // page-aligned full request, single bytes at the page edge
        send_request(OP_WRITE, {12'd10, 9'd0}, 13'd4096, 16'h0001);
        send_request(OP_WRITE, {12'd17, 9'd511}, 13'd1, '0);
        send_request(OP_WRITE, {12'd17, 9'd511}, 13'd2, 16'h7fff);
        send_request(OP_WRITE, {12'd2048, 9'd256}, 13'd4097, 16'haaaa);
        send_request(OP_READ, {12'd2730, 9'd341}, 13'd5000, 16'h5555);
        send_request(OP_COMMIT, '0, '0, '0);
        send_request(OP_READ, '0, '0, '1);

        while (sent_reqs < REQUEST_TARGET)
            random_request();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;

        while (pending_count != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests planned, %0d flash commands compared in %0d cycles",
                 request_count, command_count, cycle_count);
        $display("%s%s", "reads, writes, commits and ignored words, with hits, write-backs, ",
                 "wraps and a long output hold-off");
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/fpbwb_pkg.sv
hw/rtl/fpbwb_ctrl.sv
hw/rtl/fpbwb_dp.sv
hw/rtl/flash_page_buffer_write_back.sv
hw/rtl/fpbwb_checker.sv
tb/fpbwb_command_checker.sv
tb/tb.sv
